### rtl/rotated_pixel_write_packer_core_defines.svh
// Assertion macros for the pixel write packer core.
// Included by the top level; no other dependency.
`ifndef ROTATED_PIXEL_WRITE_PACKER_CORE_DEFINES_SVH
`define ROTATED_PIXEL_WRITE_PACKER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked while out of reset
`define RPWP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pixel packer check failed");
// Next-cycle implication, checked while out of reset
`define RPWP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pixel packer check failed");
`else
`define RPWP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RPWP_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### rtl/rpwp_pkg.sv
// Shared constants and helpers for the pixel write packer core.
// No dependencies; used by rotated_pixel_write_packer_core.
package rpwp_pkg;

    // Stream payload widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 64;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 15;

    // Largest logical dimension, used as the width/height reset value
    localparam logic [12:0] MAX_DIM = 13'd4096;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_ROTATION    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_STRIDE      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BPP         = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_COLOR_MODE  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_CH_OFFSETS  = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_CH_LENGTHS  = 3'd7;

    // Rotation codes
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // Color mode codes; anything above GENERIC acts as GENERIC
    localparam logic [2:0] CM_RGB565  = 3'd0;
    localparam logic [2:0] CM_BGR565  = 3'd1;
    localparam logic [2:0] CM_RGB888  = 3'd2;
    localparam logic [2:0] CM_BGR888  = 3'd3;
    localparam logic [2:0] CM_GENERIC = 3'd4;

    // Supported depths
    localparam logic [5:0] BPP_16 = 6'd16;
    localparam logic [5:0] BPP_24 = 6'd24;
    localparam logic [5:0] BPP_32 = 6'd32;

    // Byte masks
    localparam logic [3:0] MASK_NONE = 4'd0;
    localparam logic [3:0] MASK_16   = 4'd3;
    localparam logic [3:0] MASK_24   = 4'd7;
    localparam logic [3:0] MASK_32   = 4'd15;

    // Reset values
    localparam logic [14:0] STRIDE_RESET = 15'd16384;
    localparam logic [5:0]  BPP_RESET    = 6'd32;

    // Place one channel in the generic layout: keep the top len bits
    // (len saturates at 8), then shift to the bit offset; bits past 31 drop.
    function automatic logic [31:0] place_channel(input logic [7:0] c,
                                                  input logic [3:0] len,
                                                  input logic [4:0] off);
        logic [3:0]  l;
        logic [7:0]  kept;
        l = (len > 4'd8) ? 4'd8 : len;
        kept = c >> (4'd8 - l);
        return {24'd0, kept} << off;
    endfunction

endpackage

### rtl/rotated_pixel_write_packer_core.sv
// Pixel write packer: clip, rotate, address and color-pack one pixel per item.
// Depends on rpwp_pkg and rotated_pixel_write_packer_core_defines.svh.
//
//  channel | ports                             | contents (low bit first)
//  --------+-----------------------------------+---------------------------------------
//  input   | s_tvalid s_tready s_tdata s_tuser | pos_x, pos_y, red, green, blue; buffer
//  result  | m_tvalid m_tready m_tdata m_tuser | byte_offset, data, mask; enable, buffer
//  config  | cfg_wr_en cfg_addr cfg_wdata      | register index and value
//
// One item per clock while m_tready does not stall; an accepted item passes
// through the input register, then the result register. The offset multiplier
// py * stride_reg between the two registers sets the path length.
// Reset (synchronous, aresetn low) empties both stages and loads register defaults.
// A stall on m_tready holds the result; the input register takes an item only while empty or moving on.
`include "rotated_pixel_write_packer_core_defines.svh"

module rotated_pixel_write_packer_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pos_x[15:0], pos_y[31:16], red_in[39:32], green_in[47:40], blue_in[55:48]
    input  logic [rpwp_pkg::S_TDATA_W-1:0]      s_tdata,
    // use_back_buffer[0]
    input  logic [0:0]                          s_tuser,
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // byte_offset[25:0], write_data[57:26], byte_mask[61:58], zero[63:62]
    output logic [rpwp_pkg::M_TDATA_W-1:0]      m_tdata,
    // write_enable[0], buffer_select[1]
    output logic [1:0]                          m_tuser,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [rpwp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [rpwp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    // Configuration registers
    logic [1:0]  rotation_reg;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [14:0] stride_reg;
    logic [5:0]  bpp_reg;
    logic [2:0]  color_mode_reg;
    logic [14:0] ch_offsets_reg;
    logic [11:0] ch_lengths_reg;

    // Input stage
    logic        in_valid_reg;
    logic        in_sel_reg;
    logic [15:0] in_x_reg;
    logic [15:0] in_y_reg;
    logic [7:0]  in_r_reg;
    logic [7:0]  in_g_reg;
    logic [7:0]  in_b_reg;

    // Result stage
    logic        m_valid_reg;
    logic        m_wr_en_reg;
    logic        m_sel_reg;
    logic [25:0] m_offset_reg;
    logic [31:0] m_data_reg;
    logic [3:0]  m_mask_reg;

    // Datapath
    logic        advance;
    logic        clipped;
    logic [12:0] x13;
    logic [12:0] y13;
    logic [12:0] mirror_x;
    logic [12:0] mirror_y;
    logic [12:0] px;
    logic [12:0] py;
    logic [27:0] row_term;
    logic [15:0] col_term;
    logic        classic_mode;
    logic        swap_mode;
    logic [7:0]  lo_ch;
    logic [7:0]  hi_ch;
    logic [31:0] generic_word;
    logic [31:0] pack_data;
    logic [3:0]  pack_mask;
    logic        wr_en_next;
    logic [25:0] offset_next;
    logic [31:0] data_next;
    logic [3:0]  mask_next;

    // Move the input stage on when the result stage is empty or draining
    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = aresetn && (!in_valid_reg || advance);

    // Clip against the logical size
    always_comb begin
        clipped = in_x_reg[15] || (in_x_reg[14:0] >= {2'b00, width_reg}) ||
                  in_y_reg[15] || (in_y_reg[14:0] >= {2'b00, height_reg});
    end

    // Map the logical coordinate to a physical one
    assign x13      = in_x_reg[12:0];
    assign y13      = in_y_reg[12:0];
    assign mirror_x = width_reg - x13 - 13'd1;
    assign mirror_y = height_reg - y13 - 13'd1;

    always_comb begin
        case (rotation_reg)
            rpwp_pkg::ROT_90: begin
                px = y13;
                py = mirror_x;
            end
            rpwp_pkg::ROT_180: begin
                px = mirror_x;
                py = mirror_y;
            end
            rpwp_pkg::ROT_270: begin
                px = mirror_y;
                py = x13;
            end
            default: begin
                px = x13;
                py = y13;
            end
        endcase
    end

    // Byte offset: line term plus pixel term, wrapped to 26 bits
    assign row_term    = 28'(py) * 28'(stride_reg);
    assign col_term    = 16'(px) * 16'(bpp_reg[5:3]);
    assign offset_next = wr_en_next ? 26'(row_term + 28'(col_term)) : 26'd0;

    // Pack the color
    assign classic_mode = (color_mode_reg == rpwp_pkg::CM_RGB565) ||
                          (color_mode_reg == rpwp_pkg::CM_BGR565) ||
                          (color_mode_reg == rpwp_pkg::CM_RGB888) ||
                          (color_mode_reg == rpwp_pkg::CM_BGR888);
    assign swap_mode    = (color_mode_reg == rpwp_pkg::CM_BGR565) ||
                          (color_mode_reg == rpwp_pkg::CM_BGR888);
    assign lo_ch        = swap_mode ? in_r_reg : in_b_reg;
    assign hi_ch        = swap_mode ? in_b_reg : in_r_reg;

    assign generic_word =
        rpwp_pkg::place_channel(in_r_reg, ch_lengths_reg[11:8], ch_offsets_reg[14:10]) |
        rpwp_pkg::place_channel(in_g_reg, ch_lengths_reg[7:4], ch_offsets_reg[9:5]) |
        rpwp_pkg::place_channel(in_b_reg, ch_lengths_reg[3:0], ch_offsets_reg[4:0]);

    always_comb begin
        pack_data = 32'd0;
        pack_mask = rpwp_pkg::MASK_NONE;
        if (classic_mode) begin
            if ((bpp_reg == rpwp_pkg::BPP_24) || (bpp_reg == rpwp_pkg::BPP_32)) begin
                pack_data = {8'd0, hi_ch, in_g_reg, lo_ch};
                pack_mask = rpwp_pkg::MASK_24;
            end else if (bpp_reg == rpwp_pkg::BPP_16) begin
                pack_data = {16'd0, hi_ch[7:3], in_g_reg[7:2], lo_ch[7:3]};
                pack_mask = rpwp_pkg::MASK_16;
            end
        end else begin
            if (bpp_reg == rpwp_pkg::BPP_32) begin
                pack_data = generic_word;
                pack_mask = rpwp_pkg::MASK_32;
            end else if (bpp_reg == rpwp_pkg::BPP_16) begin
                pack_data = {16'd0, generic_word[15:0]};
                pack_mask = rpwp_pkg::MASK_16;
            end
        end
    end

    // Drop the write for clipped pixels and unsupported depths
    assign wr_en_next = !clipped && (pack_mask != rpwp_pkg::MASK_NONE);
    assign data_next  = wr_en_next ? pack_data : 32'd0;
    assign mask_next  = wr_en_next ? pack_mask : rpwp_pkg::MASK_NONE;

    // Registers: configuration, input stage, result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rotation_reg   <= rpwp_pkg::ROT_0;
            width_reg      <= rpwp_pkg::MAX_DIM;
            height_reg     <= rpwp_pkg::MAX_DIM;
            stride_reg     <= rpwp_pkg::STRIDE_RESET;
            bpp_reg        <= rpwp_pkg::BPP_RESET;
            color_mode_reg <= rpwp_pkg::CM_RGB888;
            ch_offsets_reg <= 15'd0;
            ch_lengths_reg <= 12'd0;
            in_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    rpwp_pkg::REG_ROTATION:   rotation_reg   <= cfg_wdata[1:0];
                    rpwp_pkg::REG_WIDTH:      width_reg      <= cfg_wdata[12:0];
                    rpwp_pkg::REG_HEIGHT:     height_reg     <= cfg_wdata[12:0];
                    rpwp_pkg::REG_STRIDE:     stride_reg     <= cfg_wdata[14:0];
                    rpwp_pkg::REG_BPP:        bpp_reg        <= cfg_wdata[5:0];
                    rpwp_pkg::REG_COLOR_MODE: color_mode_reg <= cfg_wdata[2:0];
                    rpwp_pkg::REG_CH_OFFSETS: ch_offsets_reg <= cfg_wdata[14:0];
                    rpwp_pkg::REG_CH_LENGTHS: ch_lengths_reg <= cfg_wdata[11:0];
                    default: begin
                    end
                endcase
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                m_valid_reg <= in_valid_reg;
            end
        end

        // Capture an accepted item
        if (s_tvalid && s_tready) begin
            in_sel_reg <= s_tuser[0];
            in_x_reg   <= s_tdata[15:0];
            in_y_reg   <= s_tdata[31:16];
            in_r_reg   <= s_tdata[39:32];
            in_g_reg   <= s_tdata[47:40];
            in_b_reg   <= s_tdata[55:48];
        end

        // Load the result when the input stage moves on
        if (advance && in_valid_reg) begin
            m_wr_en_reg  <= wr_en_next;
            m_sel_reg    <= in_sel_reg;
            m_offset_reg <= offset_next;
            m_data_reg   <= data_next;
            m_mask_reg   <= mask_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_mask_reg, m_data_reg, m_offset_reg};
    assign m_tuser  = {m_sel_reg, m_wr_en_reg};

    // A suppressed write carries all-zero offset, data and mask
    `RPWP_ASSERT_IMP(a_disabled_zero, aclk, aresetn,
        m_valid_reg && !m_wr_en_reg,
        (m_offset_reg == 26'd0) && (m_data_reg == 32'd0) && (m_mask_reg == rpwp_pkg::MASK_NONE))
    // An issued write has one of the legal byte masks
    `RPWP_ASSERT_IMP(a_mask_legal, aclk, aresetn,
        m_valid_reg && m_wr_en_reg,
        (m_mask_reg == rpwp_pkg::MASK_16) || (m_mask_reg == rpwp_pkg::MASK_24) ||
        (m_mask_reg == rpwp_pkg::MASK_32))
    // A 16-bit write leaves the upper half of the data clear
    `RPWP_ASSERT_IMP(a_half_word_clean, aclk, aresetn,
        m_valid_reg && (m_mask_reg == rpwp_pkg::MASK_16),
        m_data_reg[31:16] == 16'd0)
    // An item leaving the input stage shows up as a result next cycle
    `RPWP_ASSERT_NXT(a_stage_moves, aclk, aresetn,
        in_valid_reg && advance,
        m_valid_reg)

endmodule

### tb/sv/rotated_pixel_write_packer_core_test.sv
// Self-checking testbench for rotated_pixel_write_packer_core: a scoreboard class
// predicts each framebuffer write from its own copy of the registers.
// Depends on rpwp_pkg and the core RTL only.
`timescale 1ns / 1ps

import rpwp_pkg::*;

// One pixel as it travels on the input channel
typedef struct packed {
    logic        back;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
} pixel_t;

// One framebuffer write as it leaves the result channel
typedef struct {
    logic        en;
    logic        sel;
    logic [25:0] offset;
    logic [31:0] data;
    logic [3:0]  mask;
} fb_write_t;

class pixel_write_tracker;
    logic [1:0]  rotation;
    logic [12:0] width;
    logic [12:0] height;
    logic [14:0] stride;
    logic [5:0]  bpp;
    logic [2:0]  mode;
    logic [14:0] ch_off;
    logic [11:0] ch_len;
    fb_write_t   pending_writes[$];
    int          errors;
    int          checked;
    int          enabled;

    function new();
        rotation = ROT_0;
        width    = MAX_DIM;
        height   = MAX_DIM;
        stride   = STRIDE_RESET;
        bpp      = BPP_RESET;
        mode     = CM_RGB888;
        ch_off   = '0;
        ch_len   = '0;
        errors   = 0;
        checked  = 0;
        enabled  = 0;
    endfunction

    // Mirror a register write; the core keeps only the low bits of each value
    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        case (idx)
            REG_ROTATION:   rotation = v[1:0];
            REG_WIDTH:      width    = v[12:0];
            REG_HEIGHT:     height   = v[12:0];
            REG_STRIDE:     stride   = v[14:0];
            REG_BPP:        bpp      = v[5:0];
            REG_COLOR_MODE: mode     = v[2:0];
            REG_CH_OFFSETS: ch_off   = v[14:0];
            REG_CH_LENGTHS: ch_len   = v[11:0];
            default: ;
        endcase
    endfunction

    // Keep the top len bits of a channel (len capped at 8) and move them to bit off
    function logic [31:0] layout_channel(logic [7:0] c, logic [3:0] len, logic [4:0] off);
        int unsigned keep;
        logic [63:0] bits;
        keep = (len > 4'd8) ? 8 : len;
        bits = 64'(c) >> (8 - keep);
        return 32'(bits << off);
    endfunction

    function fb_write_t expected_write(pixel_t p);
        fb_write_t w;
        longint x, y, wd, ht, px, py, addr;
        logic [7:0] lo, hi;
        logic [31:0] word;
        logic [31:0] data;
        logic [3:0] mask;
        w.en = 1'b0;
        w.sel = p.back;
        w.offset = '0;
        w.data = '0;
        w.mask = MASK_NONE;
        x = longint'($signed(p.x));
        y = longint'($signed(p.y));
        wd = longint'(width);
        ht = longint'(height);
        if (x < 0 || x >= wd || y < 0 || y >= ht)
            return w;

        // Pack the color
        data = '0;
        mask = MASK_NONE;
        if (mode <= CM_BGR888) begin
            if (mode == CM_BGR565 || mode == CM_BGR888) begin
                lo = p.red;
                hi = p.blue;
            end else begin
                lo = p.blue;
                hi = p.red;
            end
            if (bpp == BPP_24 || bpp == BPP_32) begin
                data = {8'd0, hi, p.green, lo};
                mask = MASK_24;
            end else if (bpp == BPP_16) begin
                data = {16'd0, hi[7:3], p.green[7:2], lo[7:3]};
                mask = MASK_16;
            end
        end else begin
            word = layout_channel(p.red, ch_len[11:8], ch_off[14:10])
                 | layout_channel(p.green, ch_len[7:4], ch_off[9:5])
                 | layout_channel(p.blue, ch_len[3:0], ch_off[4:0]);
            if (bpp == BPP_32) begin
                data = word;
                mask = MASK_32;
            end else if (bpp == BPP_16) begin
                data = {16'd0, word[15:0]};
                mask = MASK_16;
            end
        end
        if (mask == MASK_NONE)
            return w;

        // Map the logical coordinate to the physical one
        case (rotation)
            ROT_90: begin
                px = y;
                py = wd - x - 1;
            end
            ROT_180: begin
                px = wd - x - 1;
                py = ht - y - 1;
            end
            ROT_270: begin
                px = ht - y - 1;
                py = x;
            end
            default: begin
                px = x;
                py = y;
            end
        endcase
        addr = py * longint'(stride) + px * longint'(bpp >> 3);
        w.en = 1'b1;
        w.offset = addr[25:0];
        w.data = data;
        w.mask = mask;
        return w;
    endfunction

    function void note_pixel(pixel_t p);
        pending_writes.push_back(expected_write(p));
    endfunction

    function int pending_count();
        return pending_writes.size();
    endfunction

    function void compare_field(string what, logic [31:0] want, logic [31:0] seen);
        if (want !== seen) begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, what, want, seen);
        end
    endfunction

    function void check_write(fb_write_t got);
        fb_write_t want;
        if (pending_writes.size() == 0) begin
            errors++;
            $display("%0t: write with no pixel pending, expected none, actual en %0b offset %0h data %0h",
                     $time, got.en, got.offset, got.data);
            return;
        end
        want = pending_writes.pop_front();
        compare_field("write_enable", 32'(want.en), 32'(got.en));
        compare_field("buffer_select", 32'(want.sel), 32'(got.sel));
        compare_field("byte_offset", 32'(want.offset), 32'(got.offset));
        compare_field("write_data", want.data, got.data);
        compare_field("byte_mask", 32'(want.mask), 32'(got.mask));
        checked++;
        if (want.en)
            enabled++;
    endfunction
endclass

module rotated_pixel_write_packer_core_test;
    localparam int PHASES = 20;
    localparam int ITEMS_PER_PHASE = 45;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    pixel_write_tracker tracker = new();
    int send_idle_pct = 26;
    int recv_idle_pct = 76;
    int settings_count = 1;

    rotated_pixel_write_packer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the core hangs
    initial begin
        #(2_000_000);
        $display("rotated_pixel_write_packer_core: mismatch");
        $finish;
    end

    // Receiver backpressure, refreshed on every falling edge
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Track accepted pixels and check each write against the oldest prediction
    always @(posedge aclk) begin
        fb_write_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                tracker.note_pixel(pixel_t'({s_tuser[0], s_tdata[15:0], s_tdata[31:16],
                                             s_tdata[39:32], s_tdata[47:40], s_tdata[55:48]}));
            if (m_tvalid && m_tready) begin
                got.en = m_tuser[0];
                got.sel = m_tuser[1];
                got.offset = m_tdata[25:0];
                got.data = m_tdata[57:26];
                got.mask = m_tdata[61:58];
                tracker.check_write(got);
            end
        end
    end

    // Write one register; called at a falling edge while the core is idle
    task write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        tracker.set_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Offer one pixel, with random idle cycles ahead of it, and hold until taken
    task send_pixel(input pixel_t p);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {p.blue, p.green, p.red, p.y, p.x};
        s_tuser <= p.back;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task send_xy(input logic back, input int x, input int y,
                 input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        send_pixel('{back, 16'(x), 16'(y), r, g, b});
    endtask

    // Hold the sender until every predicted write has come back, then let the
    // two pipeline stages settle
    task wait_for_writes();
        s_tvalid <= 1'b0;
        while (tracker.pending_count() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Mostly in-range coordinates, with clip edges and raw 16-bit values mixed in
    function logic [15:0] pick_coord(int lim);
        logic [15:0] v;
        case ($urandom_range(9))
            0: v = 16'($urandom);
            1: begin
                case ($urandom_range(3))
                    0: v = 16'hFFFF;
                    1: v = 16'h0000;
                    2: v = 16'(lim - 1);
                    default: v = 16'(lim);
                endcase
            end
            default: v = (lim > 0) ? 16'($urandom_range(lim - 1)) : 16'($urandom_range(15));
        endcase
        return v;
    endfunction

    // Register setting for one random phase; a few phases pin the extremes
    task set_phase_regs(input int i);
        int w, h, s, d;
        case (i)
            1: w = 0;
            2: w = 1;
            3: w = 8191;
            4: w = 4096;
            default: w = $urandom_range(64, 1);
        endcase
        case (i)
            1: h = 1;
            2: h = 0;
            3: h = 4096;
            4: h = 8191;
            default: h = $urandom_range(64, 1);
        endcase
        case (i)
            0: s = 16384;
            5: s = 0;
            6: s = 32767;
            default: s = $urandom_range(32767);
        endcase
        case (i)
            6: d = 0;
            9: d = $urandom_range(63);
            13: d = 63;
            default: begin
                case ($urandom_range(2))
                    0: d = BPP_16;
                    1: d = BPP_24;
                    default: d = BPP_32;
                endcase
            end
        endcase
        write_reg(REG_ROTATION, 15'(i % 4));
        write_reg(REG_WIDTH, 15'(w));
        write_reg(REG_HEIGHT, 15'(h));
        write_reg(REG_STRIDE, 15'(s));
        write_reg(REG_BPP, 15'(d));
        write_reg(REG_COLOR_MODE, 15'(i % 8));
        if (i == 7) begin
            write_reg(REG_CH_OFFSETS, 15'h7FFF);
            write_reg(REG_CH_LENGTHS, 15'h0FFF);
        end else if (i == 15) begin
            write_reg(REG_CH_OFFSETS, 15'h0000);
            write_reg(REG_CH_LENGTHS, 15'h0000);
        end else begin
            write_reg(REG_CH_OFFSETS, 15'($urandom));
            write_reg(REG_CH_LENGTHS, 15'($urandom_range(12'hFFF)));
        end
        settings_count++;
    endtask

    initial begin
        pixel_t p;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset registers: corners, clip edges and extreme coordinates
        send_xy(1'b0, 0, 0, 8'h00, 8'h00, 8'h00);
        send_xy(1'b1, 4095, 4095, 8'hFF, 8'hFF, 8'hFF);
        send_xy(1'b0, -1, 0, 8'h11, 8'h22, 8'h33);
        send_xy(1'b1, 0, -1, 8'h44, 8'h55, 8'h66);
        send_xy(1'b0, 4096, 0, 8'h77, 8'h88, 8'h99);
        send_xy(1'b1, 0, 4096, 8'hAA, 8'hBB, 8'hCC);
        send_xy(1'b0, -32768, 32767, 8'hFF, 8'h00, 8'hFF);
        send_xy(1'b1, 32767, -32768, 8'h00, 8'hFF, 8'h00);
        send_xy(1'b0, 1, 2, 8'h12, 8'h34, 8'h56);
        send_xy(1'b1, 4095, 0, 8'hFF, 8'h00, 8'h00);
        send_xy(1'b0, 0, 4095, 8'h00, 8'hFF, 8'h00);
        send_xy(1'b1, 7, 9, 8'h00, 8'h00, 8'hFF);
        wait_for_writes();

        // Small 16-bit surface: corners under each non-zero rotation
        write_reg(REG_WIDTH, 15'd5);
        write_reg(REG_HEIGHT, 15'd3);
        write_reg(REG_STRIDE, 15'd64);
        write_reg(REG_BPP, 15'(BPP_16));
        write_reg(REG_COLOR_MODE, 15'(CM_RGB565));
        for (int r = 1; r < 4; r++) begin
            write_reg(REG_ROTATION, 15'(r));
            settings_count++;
            send_xy(1'b0, 0, 0, 8'hF8, 8'hFC, 8'hF8);
            send_xy(1'b1, 4, 2, 8'h08, 8'h04, 8'h08);
            send_xy(1'b0, 4, 0, 8'h5A, 8'hA5, 8'h3C);
            wait_for_writes();
        end

        // Random phases: sender idles lightly, then the receiver, then neither
        for (int i = 0; i < PHASES; i++) begin
            if (i < 7) begin
                send_idle_pct = 26;
                recv_idle_pct = 76;
            end else if (i < 14) begin
                send_idle_pct = 76;
                recv_idle_pct = 26;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_phase_regs(i);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                p.back = 1'($urandom_range(1));
                p.x = pick_coord(int'(tracker.width));
                p.y = pick_coord(int'(tracker.height));
                p.red = 8'($urandom);
                p.green = 8'($urandom);
                p.blue = 8'($urandom);
                send_pixel(p);
                if ($urandom_range(99) == 0)
                    wait_for_writes();
            end
            wait_for_writes();
        end

        $display("%0d pixels checked, %0d of them written, over %0d register settings",
                 tracker.checked, tracker.enabled, settings_count);
        $display("covered all rotations, color modes, clip edges and unsupported depths");
        if (tracker.errors == 0 && tracker.pending_count() == 0) begin
            $display("rotated_pixel_write_packer_core: match");
        end else begin
            $display("rotated_pixel_write_packer_core: mismatch");
        end
        $finish;
    end
endmodule
